### hdl/esc_pkg.sv
// Shared types, constants and helper functions for the sensor compensation core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package esc_pkg;

  localparam int FRONT_LAT = 10;
  localparam int DIV_LAT   = 32;
  localparam int TAIL_LAT  = 4;
  localparam int HUM_LAT   = 12;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic [31:0] C_TF_OFS   = 32'd64000;
  localparam logic [31:0] C_P_BASE   = 32'd1048576;
  localparam logic [31:0] C_P_SCALE  = 32'd3125;
  localparam logic [31:0] C_HALF     = 32'd32768;
  localparam logic [31:0] C_H_OFS    = 32'd76800;
  localparam logic [31:0] C_H_RND    = 32'd16384;
  localparam logic [31:0] C_H_BIAS   = 32'd2097152;
  localparam logic [31:0] C_H_RND2   = 32'd8192;
  localparam logic [31:0] C_HUM_MAX  = 32'd419430400;
  localparam logic [31:0] C_TC_RND   = 32'd128;

  typedef enum logic [2:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_PRESS_C = 3'd3,
    REG_CAL_HUM_A   = 3'd4,
    REG_CAL_HUM_B   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } esc_cal_t;

  typedef struct packed {
    logic big;
    logic inv;
  } esc_tag_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

### hdl/env_sensor_compensation_core.sv
// Top level of the sensor compensation core: ports, latency alignment, output strobe.
// Depends on esc_pkg, esc_regs, esc_front, esc_div, esc_tail and esc_hum.
//
// channel   direction  handshake                       payload
// reading   in         start & !busy                   raw_temp, raw_press, raw_hum
// result    out        done, one cycle                 temp_centi, fine_temp, press_pa,
//                                                      press_invalid, hum_q10
// config    in         psel & penable & pwrite         paddr, pwdata (prdata on read)
//
// One reading enters every cycle; busy stays low.
// Results pass through the 10-stage front end, the 32-stage divider and the pressure tail.
// Synchronous reset clears the valid chains and all coefficients.
// The receiver cannot stall, so nothing is held back.
`timescale 1ns / 1ps
module env_sensor_compensation_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [19:0]                 raw_temp,
  input  logic [19:0]                 raw_press,
  input  logic [15:0]                 raw_hum,
  output logic                        done,
  output logic signed [31:0]          temp_centi,
  output logic signed [31:0]          fine_temp,
  output logic [31:0]                 press_pa,
  output logic                        press_invalid,
  output logic [16:0]                 hum_q10,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esc_pkg::ADDR_W-1:0]  paddr,
  input  logic [esc_pkg::DATA_W-1:0]  pwdata,
  output logic [esc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import esc_pkg::*;

  localparam int TEMP_DLY = DIV_LAT + TAIL_LAT;
  localparam int HUM_DLY  = DIV_LAT + TAIL_LAT - HUM_LAT;
  localparam int TOT_LAT  = FRONT_LAT + DIV_LAT + TAIL_LAT;

  esc_cal_t    cal;
  logic        f_vld, d_vld, h_vld;
  logic [31:0] f_tf, f_tc, f_dvd, f_dsr, d_quot;
  logic [15:0] f_ah;
  esc_tag_t    f_tag, d_tag;
  logic [16:0] h_q10;
  logic [31:0] tf_d [0:TEMP_DLY-1];
  logic [31:0] tc_d [0:TEMP_DLY-1];
  logic [16:0] hq_d [0:HUM_DLY-1];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  esc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cal
  );

  esc_front u_front (
    .clk, .rst,
    .in_vld   (start & ~busy),
    .raw_temp, .raw_press, .raw_hum, .cal,
    .out_vld  (f_vld),
    .tf       (f_tf),
    .tc       (f_tc),
    .adc_h    (f_ah),
    .dividend (f_dvd),
    .divisor  (f_dsr),
    .tag      (f_tag)
  );

  esc_div u_div (
    .clk, .rst,
    .in_vld   (f_vld),
    .dividend (f_dvd),
    .divisor  (f_dsr),
    .in_tag   (f_tag),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .out_tag  (d_tag)
  );

  esc_tail u_tail (
    .clk, .rst,
    .in_vld  (d_vld),
    .quot    (d_quot),
    .tag     (d_tag),
    .cal,
    .out_vld (done),
    .press_pa,
    .press_invalid
  );

  esc_hum u_hum (
    .clk, .rst,
    .in_vld  (f_vld),
    .tf      (f_tf),
    .adc_h   (f_ah),
    .cal,
    .out_vld (h_vld),
    .hum_q10 (h_q10)
  );

  always_ff @(posedge clk) begin
    tf_d[0] <= f_tf;
    tc_d[0] <= f_tc;
    hq_d[0] <= h_q10;
    for (int k = 1; k < TEMP_DLY; k++) begin
      tf_d[k] <= tf_d[k-1];
      tc_d[k] <= tc_d[k-1];
    end
    for (int k = 1; k < HUM_DLY; k++) hq_d[k] <= hq_d[k-1];
  end

  assign fine_temp  = $signed(tf_d[TEMP_DLY-1]);
  assign temp_centi = $signed(tc_d[TEMP_DLY-1]);
  assign hum_q10    = hq_d[HUM_DLY-1];

  a_lat : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOT_LAT))
    else $error("result without a matching accepted reading");

  a_align : assert property (@(posedge clk) disable iff (rst)
    h_vld |-> ##HUM_DLY done)
    else $error("humidity path out of step with pressure path");

  a_inv : assert property (@(posedge clk) disable iff (rst)
    (done && press_invalid) |-> (press_pa == '0))
    else $error("invalid pressure not zeroed");

  a_clamp : assert property (@(posedge clk) disable iff (rst)
    done |-> (hum_q10 <= 17'd102400))
    else $error("humidity exceeds clamp");

endmodule

### hdl/esc_regs.sv
// Calibration register file behind the APB-style configuration port.
// Depends on esc_pkg for register indexes and the coefficient struct.
`timescale 1ns / 1ps
module esc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esc_pkg::ADDR_W-1:0]  paddr,
  input  logic [esc_pkg::DATA_W-1:0]  pwdata,
  output logic [esc_pkg::DATA_W-1:0]  prdata,
  output esc_pkg::esc_cal_t           cal
);
  import esc_pkg::*;

  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;
  logic [31:0] cal_hum_a;
  logic [47:0] cal_hum_b;
  logic        wr;
  reg_idx_t    idx;

  assign wr  = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_press_c <= '0;
      cal_hum_a   <= '0;
      cal_hum_b   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_CAL_TEMP:    cal_temp    <= pwdata[47:0];
        REG_CAL_PRESS_A: cal_press_a <= pwdata;
        REG_CAL_PRESS_B: cal_press_b <= pwdata;
        REG_CAL_PRESS_C: cal_press_c <= pwdata[15:0];
        REG_CAL_HUM_A:   cal_hum_a   <= pwdata[31:0];
        REG_CAL_HUM_B:   cal_hum_b   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAL_TEMP:    prdata = {16'd0, cal_temp};
      REG_CAL_PRESS_A: prdata = cal_press_a;
      REG_CAL_PRESS_B: prdata = cal_press_b;
      REG_CAL_PRESS_C: prdata = {48'd0, cal_press_c};
      REG_CAL_HUM_A:   prdata = {32'd0, cal_hum_a};
      REG_CAL_HUM_B:   prdata = {16'd0, cal_hum_b};
      default:         prdata = '0;
    endcase
  end

  assign cal.t1 = {16'd0, cal_temp[15:0]};
  assign cal.t2 = sx16(cal_temp[31:16]);
  assign cal.t3 = sx16(cal_temp[47:32]);
  assign cal.p1 = {16'd0, cal_press_a[15:0]};
  assign cal.p2 = sx16(cal_press_a[31:16]);
  assign cal.p3 = sx16(cal_press_a[47:32]);
  assign cal.p4 = sx16(cal_press_a[63:48]);
  assign cal.p5 = sx16(cal_press_b[15:0]);
  assign cal.p6 = sx16(cal_press_b[31:16]);
  assign cal.p7 = sx16(cal_press_b[47:32]);
  assign cal.p8 = sx16(cal_press_b[63:48]);
  assign cal.p9 = sx16(cal_press_c);
  assign cal.h1 = {24'd0, cal_hum_a[7:0]};
  assign cal.h3 = {24'd0, cal_hum_a[15:8]};
  assign cal.h2 = sx16(cal_hum_a[31:16]);
  assign cal.h4 = sx16(cal_hum_b[15:0]);
  assign cal.h5 = sx16(cal_hum_b[31:16]);
  assign cal.h6 = sx16(cal_hum_b[47:32]);

endmodule

### hdl/esc_front.sv
// Front pipeline: fine temperature, temperature and pressure dividend/divisor.
// Depends on esc_pkg for coefficients, constants and shift helpers.
`timescale 1ns / 1ps
module esc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [19:0]       raw_temp,
  input  logic [19:0]       raw_press,
  input  logic [15:0]       raw_hum,
  input  esc_pkg::esc_cal_t cal,
  output logic              out_vld,
  output logic [31:0]       tf,
  output logic [31:0]       tc,
  output logic [15:0]       adc_h,
  output logic [31:0]       dividend,
  output logic [31:0]       divisor,
  output esc_pkg::esc_tag_t tag
);
  import esc_pkg::*;

  logic [FRONT_LAT-1:0] vld;
  logic [31:0] m1, bb, v1t, m2, pv1, qq, mp5, mp2, v2a, a3, b6, mp5_6;
  logic [31:0] v2, pv1b, mp1, pnp, d9, pn9;
  logic [31:0] tf_c [3:10];
  logic [31:0] tc_c [4:10];
  logic [15:0] ah_c [1:10];
  logic [19:0] ap_c [1:7];
  logic [31:0] bt, q;

  assign bt = (32'(raw_temp) >> 4) - cal.t1;
  assign q  = asr(pv1, 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    m1 <= ((32'(raw_temp) >> 3) - (cal.t1 << 1)) * cal.t2;
    bb <= bt * bt;
    ah_c[1] <= raw_hum;
    ap_c[1] <= raw_press;
    for (int k = 2; k <= 10; k++) ah_c[k] <= ah_c[k-1];
    for (int k = 2; k <= 7; k++) ap_c[k] <= ap_c[k-1];

    v1t <= asr(m1, 11);
    m2  <= asr(bb, 12) * cal.t3;

    tf_c[3] <= v1t + asr(m2, 14);
    for (int k = 4; k <= 10; k++) tf_c[k] <= tf_c[k-1];

    tc_c[4] <= asr((tf_c[3] << 2) + tf_c[3] + C_TC_RND, 8);
    for (int k = 5; k <= 10; k++) tc_c[k] <= tc_c[k-1];
    pv1 <= asr(tf_c[3], 1) - C_TF_OFS;

    qq  <= q * q;
    mp5 <= pv1 * cal.p5;
    mp2 <= cal.p2 * pv1;

    v2a   <= asr(qq, 11) * cal.p6;
    a3    <= asr(qq, 13) * cal.p3;
    b6    <= asr(mp2, 1);
    mp5_6 <= mp5;

    v2   <= asr(v2a + (mp5_6 << 1), 2) + (cal.p4 << 16);
    pv1b <= asr(asr(a3, 3) + b6, 18);

    mp1 <= (C_HALF + pv1b) * cal.p1;
    pnp <= (C_P_BASE - 32'(ap_c[7])) - asr(v2, 12);

    d9  <= asr(mp1, 15);
    pn9 <= pnp * C_P_SCALE;

    dividend <= pn9[31] ? pn9 : (pn9 << 1);
    divisor  <= d9;
    tag.big  <= pn9[31];
    tag.inv  <= (d9 == '0);
  end

  assign out_vld = vld[FRONT_LAT-1];
  assign tf      = tf_c[10];
  assign tc      = tc_c[10];
  assign adc_h   = ah_c[10];

endmodule

### hdl/esc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned 32/32.
// Depends on esc_pkg for the stage count and the sideband tag type.
`timescale 1ns / 1ps
module esc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [31:0]       dividend,
  input  logic [31:0]       divisor,
  input  esc_pkg::esc_tag_t in_tag,
  output logic              out_vld,
  output logic [31:0]       quot,
  output esc_pkg::esc_tag_t out_tag
);
  import esc_pkg::*;

  logic [DIV_LAT-1:0] vld;
  logic [31:0] rem [0:DIV_LAT-1];
  logic [31:0] num [0:DIV_LAT-1];
  logic [31:0] den [0:DIV_LAT-1];
  esc_tag_t    tg  [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_LAT-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [31:0] rem_in, num_in, den_in;
    esc_tag_t    tg_in;
    logic [33:0] trial;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign den_in = divisor;
      assign tg_in  = in_tag;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign num_in = num[k-1];
      assign den_in = den[k-1];
      assign tg_in  = tg[k-1];
    end
    assign trial = {1'b0, rem_in, num_in[31]} - {2'b00, den_in};
    assign ge    = ~trial[33];
    always_ff @(posedge clk) begin
      rem[k] <= ge ? trial[31:0] : {rem_in[30:0], num_in[31]};
      num[k] <= {num_in[30:0], ge};
      den[k] <= den_in;
      tg[k]  <= tg_in;
    end
  end

  assign out_vld = vld[DIV_LAT-1];
  assign quot    = num[DIV_LAT-1];
  assign out_tag = tg[DIV_LAT-1];

endmodule

### hdl/esc_tail.sv
// Pressure back end: quotient scaling and the final P7..P9 correction.
// Depends on esc_pkg for coefficients, tag type and shift helpers.
`timescale 1ns / 1ps
module esc_tail (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [31:0]       quot,
  input  esc_pkg::esc_tag_t tag,
  input  esc_pkg::esc_cal_t cal,
  output logic              out_vld,
  output logic [31:0]       press_pa,
  output logic              press_invalid
);
  import esc_pkg::*;

  logic [TAIL_LAT-1:0] vld;
  logic [31:0] p1, p2, p3, sq, m8, w1m, w2;
  logic        inv1, inv2, inv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TAIL_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    p1   <= tag.big ? (quot << 1) : quot;
    inv1 <= tag.inv;

    sq   <= (p1 >> 3) * (p1 >> 3);
    m8   <= (p1 >> 2) * cal.p8;
    p2   <= p1;
    inv2 <= inv1;

    w1m  <= (sq >> 13) * cal.p9;
    w2   <= asr(m8, 13);
    p3   <= p2;
    inv3 <= inv2;

    press_pa      <= inv3 ? '0 : p3 + asr(asr(w1m, 12) + w2 + cal.p7, 4);
    press_invalid <= inv3;
  end

  assign out_vld = vld[TAIL_LAT-1];

endmodule

### hdl/esc_hum.sv
// Humidity pipeline: H1..H6 compensation with clamp and final scaling.
// Depends on esc_pkg for coefficients, constants and shift helpers.
`timescale 1ns / 1ps
module esc_hum (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [31:0]       tf,
  input  logic [15:0]       adc_h,
  input  esc_pkg::esc_cal_t cal,
  output logic              out_vld,
  output logic [16:0]       hum_q10
);
  import esc_pkg::*;

  logic [HUM_LAT-1:0] vld;
  logic [31:0] hx, mh5, mh6, mh3, ha, hb, hs, hbs, hb2, hm, hb3, hx2, s9, ss, m11;
  logic [31:0] ha4, ha5, ha6, ha7, x9, x10, x11, xf, xc;
  logic [15:0] ah1, ah2;

  assign xf = x11 - asr(m11, 4);

  always_comb begin
    priority if (xf[31]) begin
      xc = '0;
    end else if (xf > C_HUM_MAX) begin
      xc = C_HUM_MAX;
    end else begin
      xc = xf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[HUM_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    hx  <= tf - C_H_OFS;
    ah1 <= adc_h;

    mh5 <= cal.h5 * hx;
    mh6 <= hx * cal.h6;
    mh3 <= hx * cal.h3;
    ah2 <= ah1;

    ha <= asr(((32'(ah2) << 14) - (cal.h4 << 20) - mh5) + C_H_RND, 15);
    hb <= asr(mh6, 10);
    hs <= asr(mh3, 11) + C_HALF;

    hbs <= hb * hs;
    ha4 <= ha;

    hb2 <= asr(hbs, 10) + C_H_BIAS;
    ha5 <= ha4;

    hm  <= hb2 * cal.h2;
    ha6 <= ha5;

    hb3 <= asr(hm + C_H_RND2, 14);
    ha7 <= ha6;

    hx2 <= ha7 * hb3;

    s9 <= asr(hx2, 15);
    x9 <= hx2;

    ss  <= s9 * s9;
    x10 <= x9;

    m11 <= asr(ss, 7) * cal.h1;
    x11 <= x10;

    hum_q10 <= xc[28:12];
  end

  assign out_vld = vld[HUM_LAT-1];

endmodule

### test/env_sensor_compensation_core_tb.sv
// Testbench for env_sensor_compensation_core: drives raw readings and APB writes,
// predicts compensated temperature, pressure and humidity, and checks each result.
// Depends on esc_pkg and the core RTL.
`timescale 1ns / 1ps
module env_sensor_compensation_core_tb;
  import esc_pkg::*;

  typedef struct packed {
    logic [19:0] t;
    logic [19:0] p;
    logic [15:0] h;
  } reading_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic [31:0] pa;
    logic        inv;
    logic [16:0] hum;
  } comp_t;

  logic clk = 0, rst = 1, start = 0, busy;
  logic [19:0] raw_temp = 0, raw_press = 0;
  logic [15:0] raw_hum = 0;
  logic done, press_invalid;
  logic signed [31:0] temp_centi, fine_temp;
  logic [31:0] press_pa;
  logic [16:0] hum_q10;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [DATA_W-1:0] pwdata = 0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  env_sensor_compensation_core u_top (.*);

  logic [63:0] coef [6];
  reading_t pending_q[$];
  comp_t expected_q[$];
  int mismatches = 0, idle_cycles = 0, burst = 0, gap = 0;
  bit failed = 0, feeding = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] se(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(reading_t r);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, v1, v2, q, tf, p, w1, w2, x, s;
    comp_t c;
    t1 = {16'b0, coef[REG_CAL_TEMP][15:0]};
    t2 = se(coef[REG_CAL_TEMP][31:16]);
    t3 = se(coef[REG_CAL_TEMP][47:32]);
    p1 = {16'b0, coef[REG_CAL_PRESS_A][15:0]};
    p2 = se(coef[REG_CAL_PRESS_A][31:16]);
    p3 = se(coef[REG_CAL_PRESS_A][47:32]);
    p4 = se(coef[REG_CAL_PRESS_A][63:48]);
    p5 = se(coef[REG_CAL_PRESS_B][15:0]);
    p6 = se(coef[REG_CAL_PRESS_B][31:16]);
    p7 = se(coef[REG_CAL_PRESS_B][47:32]);
    p8 = se(coef[REG_CAL_PRESS_B][63:48]);
    p9 = se(coef[REG_CAL_PRESS_C][15:0]);
    h1 = {24'b0, coef[REG_CAL_HUM_A][7:0]};
    h3 = {24'b0, coef[REG_CAL_HUM_A][15:8]};
    h2 = se(coef[REG_CAL_HUM_A][31:16]);
    h4 = se(coef[REG_CAL_HUM_B][15:0]);
    h5 = se(coef[REG_CAL_HUM_B][31:16]);
    h6 = se(coef[REG_CAL_HUM_B][47:32]);

    a = {15'b0, r.t[19:3]} - (t1 << 1);
    v1 = sra(a * t2, 11);
    b = {16'b0, r.t[19:4]} - t1;
    v2 = sra(sra(b * b, 12) * t3, 14);
    tf = v1 + v2;
    c.tf = tf;
    c.tc = sra(tf * 32'd5 + C_TC_RND, 8);

    v1 = sra(tf, 1) - C_TF_OFS;
    q = sra(v1, 2);
    v2 = sra(q * q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    a = sra(sra(q * q, 13) * p3, 3);
    b = sra(p2 * v1, 1);
    v1 = sra(a + b, 18);
    v1 = sra((C_HALF + v1) * p1, 15);
    c.inv = (v1 == 0);
    if (c.inv) begin
      p = 0;
    end else begin
      p = ((C_P_BASE - {12'b0, r.p}) - sra(v2, 12)) * C_P_SCALE;
      if (!p[31]) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      w1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      w2 = sra((p >> 2) * p8, 13);
      p = p + sra(w1 + w2 + p7, 4);
    end
    c.pa = p;

    x = tf - C_H_OFS;
    a = sra((({16'b0, r.h} << 14) - (h4 << 20) - h5 * x) + C_H_RND, 15);
    b = sra(x * h6, 10);
    s = sra(x * h3, 11) + C_HALF;
    b = sra(b * s, 10) + C_H_BIAS;
    b = sra(b * h2 + C_H_RND2, 14);
    x = a * b;
    s = sra(x, 15);
    x = x - sra(sra(s * s, 7) * h1, 4);
    if (x[31]) x = 0;
    else if (x > C_HUM_MAX) x = C_HUM_MAX;
    c.hum = x[28:12];
    return c;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CAL_TEMP, REG_CAL_HUM_B: coef[idx] = val & 64'hFFFF_FFFF_FFFF;
      REG_CAL_PRESS_C: coef[idx] = val & 64'hFFFF;
      REG_CAL_HUM_A: coef[idx] = val & 64'hFFFF_FFFF;
      default: coef[idx] = val;
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic reading_t rand_reading();
    reading_t r;
    r.t = $urandom; r.p = $urandom; r.h = $urandom;
    case ($urandom_range(0, 7))
      0: r.t = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      1: r.p = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      2: r.h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      default: ;
    endcase
    return r;
  endfunction

  // Plausible coefficients keep most readings in the interesting range.
  task automatic load_typical();
    write_reg(REG_CAL_TEMP, {16'd50, 16'd26435, 16'd27504 + 16'($urandom_range(0, 2000))});
    write_reg(REG_CAL_PRESS_A, {16'd2855, 16'hD0A8 ^ 16'($urandom_range(0, 255)),
                                -16'sd10685, 16'd36477 + 16'($urandom_range(0, 2000))});
    write_reg(REG_CAL_PRESS_B, {16'hEC5E ^ 16'($urandom_range(0, 15)), 16'd15500,
                                -16'sd7, 16'd140});
    write_reg(REG_CAL_PRESS_C, 64'(16'd6000 + 16'($urandom_range(0, 100))));
    write_reg(REG_CAL_HUM_A, {16'd362, 8'd0, 8'd75});
    write_reg(REG_CAL_HUM_B, {16'd30, 16'd50, 16'd300 + 16'($urandom_range(0, 100))});
  endtask

  task automatic load_random();
    write_reg(REG_CAL_TEMP, {$urandom, $urandom});
    write_reg(REG_CAL_PRESS_A, {$urandom, $urandom});
    write_reg(REG_CAL_PRESS_B, {$urandom, $urandom});
    write_reg(REG_CAL_PRESS_C, {$urandom, $urandom});
    write_reg(REG_CAL_HUM_A, {$urandom, $urandom});
    write_reg(REG_CAL_HUM_B, {$urandom, $urandom});
  endtask

  task automatic load_all(logic [63:0] v);
    for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), v);
  endtask

  task automatic run_batch(int n);
    for (int i = 0; i < n; i++) pending_q.push_back(rand_reading());
    feeding = 1;
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    feeding = 0;
    repeat (60) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst || !feeding || pending_q.size() == 0) begin
      start <= 0;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 0;
    end else begin
      start <= 1;
      raw_temp <= pending_q[0].t;
      raw_press <= pending_q[0].p;
      raw_hum <= pending_q[0].h;
    end
  end

  // accept, predict, check
  always @(posedge clk) begin
    comp_t exp_c, got;
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        expected_q.push_back(compensate(pending_q.pop_front()));
        if (burst > 0) begin
          burst <= burst - 1;
        end else begin
          burst <= $urandom_range(0, 40);
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (done) begin
        got = '{temp_centi, fine_temp, press_pa, press_invalid, hum_q10};
        if (expected_q.size() == 0) begin
          failed <= 1;
          if (mismatches < 10) $display("ERROR: result with nothing expected: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          exp_c = expected_q.pop_front();
          if (got !== exp_c) begin
            failed <= 1;
            if (mismatches < 10) $display("ERROR: expected %p, got %p", exp_c, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (idle_cycles > 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    reading_t r;
    for (int i = 0; i < 6; i++) coef[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 0;
    // all coefficients zero: pressure invalid
    r = '{20'h0, 20'h0, 16'h0}; pending_q.push_back(r);
    r = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF}; pending_q.push_back(r);
    feeding = 1;
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    feeding = 0;
    repeat (60) @(posedge clk);
    load_typical();
    for (int i = 0; i < 4; i++) begin
      r = '{20'(i * 20'h55555), 20'hFFFFF - 20'(i * 20'h55555), 16'(i * 16'h5555)};
      pending_q.push_back(r);
    end
    r = '{20'd519888, 20'd415148, 16'd30000}; pending_q.push_back(r);
    r = '{20'd600000, 20'd300000, 16'd65535}; pending_q.push_back(r);
    r = '{20'd400000, 20'd500000, 16'd0}; pending_q.push_back(r);
    run_batch(300);
    load_all(64'hFFFF_FFFF_FFFF_FFFF);
    run_batch(100);
    load_all(64'h8000_8000_8000_8000);
    run_batch(100);
    load_random();
    run_batch(150);
    load_typical();
    run_batch(250);
    load_random();
    run_batch(140);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
